// ----- rtl/floating_strip_charge_share_core_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef FLOATING_STRIP_CHARGE_SHARE_CORE_MACROS_SVH
`define FLOATING_STRIP_CHARGE_SHARE_CORE_MACROS_SVH

// Check that holds at every edge outside reset.
`define FSCS_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define FSCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fscs_pkg.sv -----
`default_nettype none

package fscs_pkg;

    localparam int unsigned EW = 24;
    localparam logic [EW-1:0] E_MAX = {EW{1'b1}};
    // ceil(2^25 / 3): exact floor(x/3) for x < 2^25
    localparam logic [23:0] DIV3_MUL = 24'hAAAAAB;
    localparam int unsigned DIV3_SHIFT = 25;

    // Divisor code d selects a division by 2*d (d = 1..3).
    localparam logic [1:0] DIV_BY_2 = 2'd1;
    localparam logic [1:0] DIV_BY_4 = 2'd2;
    localparam logic [1:0] DIV_BY_6 = 2'd3;

    typedef struct packed {
        logic [EW-1:0] x;
        logic [1:0]    code;
    } t_div_req;

    function automatic logic [EW-1:0] sat_add(input logic [EW-1:0] a, input logic [EW-1:0] b);
        logic [EW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[EW] ? E_MAX : s[EW-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fscs_div_unit.sv -----
`default_nettype none

module fscs_div_unit (
    input  wire logic                        i_clk,
    input  wire fscs_pkg::t_div_req          i_req,
    output logic [fscs_pkg::EW-1:0]          o_quot
);

    logic [fscs_pkg::EW-2:0]          half;
    logic [fscs_pkg::EW-2+24:0]       prod;
    logic [fscs_pkg::EW-1:0]          n_quot;

    assign half = i_req.x[fscs_pkg::EW-1:1];
    assign prod = 47'(half) * 47'(fscs_pkg::DIV3_MUL);

    always_comb begin
        case (i_req.code)
            fscs_pkg::DIV_BY_2: n_quot = {1'b0, i_req.x[fscs_pkg::EW-1:1]};
            fscs_pkg::DIV_BY_4: n_quot = {2'b00, i_req.x[fscs_pkg::EW-1:2]};
            fscs_pkg::DIV_BY_6: n_quot = fscs_pkg::EW'(prod >> fscs_pkg::DIV3_SHIFT);
            default:            n_quot = i_req.x;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_quot <= n_quot;
    end

endmodule

`default_nettype wire

// ----- rtl/floating_strip_charge_share_core.sv -----
// Floating-strip charge sharing. Strip energies arrive one per beat, ladder by ladder, in
// groups of JUMP strips (one read-out strip, then JUMP-1 floating strips); one result beat
// per closed group carries the read-out strip's shared energy. All shares are computed by
// a single divide-by-2/4/6 unit (reciprocal multiply for the /6 case, registered result)
// under a small sequencer: a read-out or zero floating strip is taken at once, a nonzero
// floating strip has its share divided and then accumulated, and a group that closes
// divides and accumulates in turn the shares of the n nonzero floating strips that it
// holds (n <= JUMP-1) before its result beat. The input is not ready while a beat is
// being worked on, or while a closed group waits for the output register to free.
`default_nettype none

`include "floating_strip_charge_share_core_macros.svh"

module floating_strip_charge_share_core #(
    parameter int unsigned JUMP              = 3,
    parameter int unsigned STRIPS_PER_LADDER = 384,
    parameter int unsigned LADDERS_PER_ROW   = 4,
    parameter int unsigned NUM_LADDERS       = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [23:0] strip_energy
    input  wire logic        i_s_tlast,   // frame_end
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // [7:0] ladder_index, [16:8] strip_index,
                                          // [40:17] shared_energy, [47:41] zero
    output logic             o_m_tlast    // last_of_frame
);

    localparam int unsigned EW    = fscs_pkg::EW;
    localparam int unsigned SW    = $clog2(STRIPS_PER_LADDER);
    localparam int unsigned LW    = (NUM_LADDERS > 1) ? $clog2(NUM_LADDERS) : 1;
    localparam int unsigned RW    = (LADDERS_PER_ROW > 1) ? $clog2(LADDERS_PER_ROW) : 1;
    localparam int unsigned PW    = $clog2(JUMP);
    localparam int unsigned NSLOT = JUMP - 1;
    localparam int unsigned SLW   = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LDIV = 7'b0000010,
        S_LACC = 7'b0000100,
        S_RDIV = 7'b0001000,
        S_RACC = 7'b0010000,
        S_RFIN = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [SW-1:0] r_strip, n_strip;
    logic [LW-1:0] r_ladder, n_ladder;
    logic [RW-1:0] r_rowpos, n_rowpos;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_s, n_s;

    logic [EW-1:0] r_active, n_active;
    logic [EW-1:0] r_carry, n_carry;
    logic [EW-1:0] r_right, n_right;
    logic [EW-1:0] r_e, n_e;
    logic [EW-1:0] r_buf [NSLOT];

    logic          r_fend, n_fend;
    logic          r_grp_end, n_grp_end;
    logic          r_row_end, n_row_end;
    logic [7:0]    r_lad_q, n_lad_q;
    logic [8:0]    r_strip_q, n_strip_q;

    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_olad, n_olad;
    logic [8:0]    r_ostrip, n_ostrip;
    logic [EW-1:0] r_oen, n_oen;
    logic          r_olast, n_olast;

    logic          accept;
    logic          ladder_end;
    logic          ladder_last;
    logic          grp_end;
    logic          row_end;
    logic          buf_we;
    logic [SW-1:0] strip_base;
    logic [EW-1:0] quot;
    logic [EW-1:0] right_sum;
    fscs_pkg::t_div_req div_req;

    fscs_div_unit u_div (
        .i_clk  (i_clk),
        .i_req  (div_req),
        .o_quot (quot)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign ladder_end  = (r_strip >= SW'(STRIPS_PER_LADDER - 1));
    assign ladder_last = (r_ladder >= LW'(NUM_LADDERS - 1));
    assign grp_end     = (r_pos >= PW'(JUMP - 1)) || ladder_end || i_s_tlast;
    assign row_end     = i_s_tlast ||
                         (ladder_end && ((r_rowpos == RW'(LADDERS_PER_ROW - 1)) || ladder_last));
    assign strip_base  = r_strip - SW'(r_pos);
    assign right_sum   = fscs_pkg::sat_add(r_right, quot);

    always_comb begin
        if (r_state == S_RDIV) begin
            div_req.x    = r_buf[r_s[SLW-1:0]];
            div_req.code = 2'(r_cnt - r_s);
        end else begin
            div_req.x    = r_e;
            div_req.code = 2'(r_cnt);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_strip   = r_strip;
        n_ladder  = r_ladder;
        n_rowpos  = r_rowpos;
        n_pos     = r_pos;
        n_cnt     = r_cnt;
        n_s       = r_s;
        n_active  = r_active;
        n_carry   = r_carry;
        n_right   = r_right;
        n_e       = r_e;
        n_fend    = r_fend;
        n_grp_end = r_grp_end;
        n_row_end = r_row_end;
        n_lad_q   = r_lad_q;
        n_strip_q = r_strip_q;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_olad    = r_olad;
        n_ostrip  = r_ostrip;
        n_oen     = r_oen;
        n_olast   = r_olast;
        buf_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_e       = i_s_tdata;
                    n_fend    = i_s_tlast;
                    n_grp_end = grp_end;
                    n_row_end = row_end;
                    n_lad_q   = 8'(r_ladder);
                    n_strip_q = 9'(strip_base);
                    n_s       = '0;
                    n_right   = '0;

                    if (r_pos == '0) begin
                        n_active = fscs_pkg::sat_add(i_s_tdata, r_carry);
                        n_carry  = '0;
                        n_cnt    = '0;
                        n_state  = grp_end ? S_EMIT : S_IDLE;
                    end else if (i_s_tdata != '0 && r_cnt < PW'(JUMP - 1)) begin
                        buf_we  = 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_LDIV;
                    end else if (grp_end) begin
                        n_state = (r_cnt == '0) ? S_EMIT : S_RDIV;
                    end

                    if (i_s_tlast) begin
                        n_strip  = '0;
                        n_ladder = '0;
                        n_rowpos = '0;
                        n_pos    = '0;
                    end else if (ladder_end) begin
                        n_strip  = '0;
                        n_ladder = ladder_last ? '0 : r_ladder + 1'b1;
                        n_rowpos = (ladder_last || r_rowpos == RW'(LADDERS_PER_ROW - 1)) ?
                                   '0 : r_rowpos + 1'b1;
                        n_pos    = '0;
                    end else begin
                        n_strip = r_strip + 1'b1;
                        n_pos   = grp_end ? '0 : r_pos + 1'b1;
                    end
                end
            end
            S_LDIV: begin
                n_state = S_LACC;
            end
            S_LACC: begin
                n_active = fscs_pkg::sat_add(r_active, quot);
                n_state  = r_grp_end ? S_RDIV : S_IDLE;
            end
            S_RDIV: begin
                n_state = S_RACC;
            end
            S_RACC: begin
                n_right = right_sum;
                n_s     = r_s + 1'b1;
                n_state = (r_s + 1'b1 == r_cnt) ? S_RFIN : S_RDIV;
            end
            S_RFIN: begin
                if (r_row_end) begin
                    n_active = fscs_pkg::sat_add(r_active, r_right);
                end else begin
                    n_carry = r_right;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_olad   = r_lad_q;
                    n_ostrip = r_strip_q;
                    n_oen    = r_active;
                    n_olast  = r_fend;
                    n_cnt    = '0;
                    if (r_fend) begin
                        n_active = '0;
                        n_carry  = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strip  <= '0;
            r_ladder <= '0;
            r_rowpos <= '0;
            r_pos    <= '0;
            r_cnt    <= '0;
            r_s      <= '0;
            r_active <= '0;
            r_carry  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strip  <= n_strip;
            r_ladder <= n_ladder;
            r_rowpos <= n_rowpos;
            r_pos    <= n_pos;
            r_cnt    <= n_cnt;
            r_s      <= n_s;
            r_active <= n_active;
            r_carry  <= n_carry;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_right   <= n_right;
        r_e       <= n_e;
        r_fend    <= n_fend;
        r_grp_end <= n_grp_end;
        r_row_end <= n_row_end;
        r_lad_q   <= n_lad_q;
        r_strip_q <= n_strip_q;
        r_olad    <= n_olad;
        r_ostrip  <= n_ostrip;
        r_oen     <= n_oen;
        r_olast   <= n_olast;
        if (buf_we) begin
            r_buf[r_cnt[SLW-1:0]] <= i_s_tdata;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {7'b0, r_oen, r_ostrip, r_olad};
    assign o_m_tlast  = r_olast;

    `FSCS_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= PW'(JUMP - 1),
        "slot count overflow")
    `FSCS_ASSERT_ALWAYS(a_rdiv_slot, i_clk, i_rst_n, !(r_state == S_RDIV) || (r_s < r_cnt),
        "right share slot out of range")
    `FSCS_ASSERT_NEXT(a_frame_clear, i_clk, i_rst_n, accept && i_s_tlast,
        r_strip == '0 && r_ladder == '0 && r_pos == '0, "position not cleared at frame end")

endmodule

`default_nettype wire
